### rtl/core/stt_pkg.sv
// Shared types and constants of the software timer task table.
// Used by the front, the back and the top level; no dependencies.
package stt_pkg;

    localparam int DATA_W      = 32;
    localparam int HANDLE_W    = 16;
    // Steps of the reciprocal multiply: one 16-bit half of each time per cycle.
    localparam int DIV_STEPS   = 2;
    localparam int CNT_W       = 1;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_DEL  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_DUE = 2'd0,
        KIND_ADD = 2'd1,
        KIND_DEL = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FINISH
    } t_back_state;

    // Classified command handed from the front to the back.
    typedef struct packed {
        t_cmd                cmd;
        logic [DATA_W-1:0]   delay_ticks;
        logic [DATA_W-1:0]   period_ticks;
        logic [HANDLE_W-1:0] handle;
        logic [DATA_W-1:0]   target;
    } t_cmd_word;

    // One result word as it leaves the block.
    typedef struct packed {
        t_kind               kind;
        logic [DATA_W-1:0]   id;
        logic [HANDLE_W-1:0] handle;
        logic                success;
        logic                last;
    } t_res_word;

endpackage

### rtl/core/stt_fifo.sv
// Small synchronous FIFO used for the command queue and the result queue.
// Depends on nothing; the word width and depth come from parameters.
module stt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             wr;
    logic             rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/core/stt_front.sv
// Front end: accepts input words, drops unknown commands and converts the add
// times to ticks by a reciprocal multiply. Uses stt_pkg types.
module stt_front #(
    parameter int TICK_UNITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [1:0]                 i_cmd,
    input  logic [stt_pkg::DATA_W-1:0] i_delay_time,
    input  logic [stt_pkg::DATA_W-1:0] i_period_time,
    input  logic [stt_pkg::HANDLE_W-1:0] i_task_handle,
    input  logic [stt_pkg::DATA_W-1:0] i_target_id,
    output logic                       o_cmd_push,
    output stt_pkg::t_cmd_word         o_cmd_word,
    input  logic                       i_cmd_full
);

    // Floor division by TICK_UNITS: multiply by the rounded-up reciprocal scaled
    // by 2^SHIFT and keep the bits above SHIFT; exact for every 32-bit time.
    localparam int SHIFT = stt_pkg::DATA_W + $clog2(TICK_UNITS);
    localparam int RCP_W = stt_pkg::DATA_W + 1;
    localparam int HALF  = stt_pkg::DATA_W / 2;
    localparam int PRD_W = HALF + RCP_W;
    localparam int ACC_W = stt_pkg::DATA_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << SHIFT) + 64'(TICK_UNITS) - 64'd1) / 64'(TICK_UNITS));

    stt_pkg::t_front_state        r_state;
    stt_pkg::t_front_state        n_state;
    stt_pkg::t_cmd                r_cmd;
    logic [stt_pkg::DATA_W-1:0]   r_dly;
    logic [stt_pkg::DATA_W-1:0]   r_per;
    logic [ACC_W-1:0]             r_dacc;
    logic [ACC_W-1:0]             r_pacc;
    logic [stt_pkg::HANDLE_W-1:0] r_handle;
    logic [stt_pkg::DATA_W-1:0]   r_target;
    logic [stt_pkg::CNT_W-1:0]    r_cnt;
    logic                         accept;
    logic                         low_half;
    logic [HALF-1:0]              d_half;
    logic [HALF-1:0]              p_half;
    logic [PRD_W-1:0]             d_prod;
    logic [PRD_W-1:0]             p_prod;

    assign accept   = i_push && !o_full;
    assign low_half = (r_cnt == '0);

    // Multiply one half of each time per cycle, low half first.
    assign d_half = low_half ? r_dly[HALF-1:0] : r_dly[stt_pkg::DATA_W-1:HALF];
    assign p_half = low_half ? r_per[HALF-1:0] : r_per[stt_pkg::DATA_W-1:HALF];
    assign d_prod = PRD_W'(d_half) * PRD_W'(RECIP);
    assign p_prod = PRD_W'(p_half) * PRD_W'(RECIP);

    always_comb begin
        n_state = r_state;
        case (r_state)
            stt_pkg::FR_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        stt_pkg::CMD_TICK: n_state = stt_pkg::FR_PUSH;
                        stt_pkg::CMD_ADD:  n_state = stt_pkg::FR_DIV;
                        stt_pkg::CMD_DEL:  n_state = stt_pkg::FR_PUSH;
                        default:           n_state = stt_pkg::FR_IDLE;
                    endcase
                end
            end
            stt_pkg::FR_DIV: begin
                if (r_cnt == stt_pkg::CNT_W'(stt_pkg::DIV_STEPS - 1)) begin
                    n_state = stt_pkg::FR_PUSH;
                end
            end
            stt_pkg::FR_PUSH: begin
                if (!i_cmd_full) begin
                    n_state = stt_pkg::FR_IDLE;
                end
            end
            default: n_state = stt_pkg::FR_IDLE;
        endcase
    end

    always_comb begin
        o_full                  = (r_state != stt_pkg::FR_IDLE);
        o_cmd_push              = (r_state == stt_pkg::FR_PUSH);
        o_cmd_word.cmd          = r_cmd;
        o_cmd_word.delay_ticks  = stt_pkg::DATA_W'(r_dacc >> SHIFT);
        o_cmd_word.period_ticks = stt_pkg::DATA_W'(r_pacc >> SHIFT);
        o_cmd_word.handle       = r_handle;
        o_cmd_word.target       = r_target;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stt_pkg::FR_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == stt_pkg::FR_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == stt_pkg::FR_IDLE && accept) begin
            r_cmd    <= stt_pkg::t_cmd'(i_cmd);
            r_dly    <= i_delay_time;
            r_per    <= i_period_time;
            r_handle <= i_task_handle;
            r_target <= i_target_id;
        end else if (r_state == stt_pkg::FR_DIV) begin
            if (low_half) begin
                r_dacc <= ACC_W'(d_prod);
                r_pacc <= ACC_W'(p_prod);
            end else begin
                r_dacc <= r_dacc + (ACC_W'(d_prod) << HALF);
                r_pacc <= r_pacc + (ACC_W'(p_prod) << HALF);
            end
        end
    end

endmodule

### rtl/core/stt_back.sv
// Back end: holds the task table and walks it one slot per cycle to tick,
// add or delete, stalled while the result queue it feeds is full; uses stt_pkg.
module stt_back #(
    parameter int MAX_TASKS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_empty,
    input  stt_pkg::t_cmd_word i_cmd_word,
    output logic               o_cmd_pop,
    output logic               o_res_push,
    output stt_pkg::t_res_word o_res_word,
    input  logic               i_res_full
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    stt_pkg::t_back_state r_state;
    stt_pkg::t_back_state n_state;
    stt_pkg::t_cmd_word   r_cmd;

    // Table storage; the live bits are flops, the rest are memories.
    logic                         r_live [MAX_TASKS];
    logic [stt_pkg::DATA_W-1:0]   r_ticks_mem  [MAX_TASKS];
    logic [stt_pkg::DATA_W-1:0]   r_reload_mem [MAX_TASKS];
    logic [stt_pkg::DATA_W-1:0]   r_id_mem     [MAX_TASKS];
    logic [stt_pkg::HANDLE_W-1:0] r_handle_mem [MAX_TASKS];
    logic [stt_pkg::DATA_W-1:0]   r_q_ticks;
    logic [stt_pkg::DATA_W-1:0]   r_q_reload;
    logic [stt_pkg::DATA_W-1:0]   r_q_id;
    logic [stt_pkg::HANDLE_W-1:0] r_q_handle;

    logic [IDX_W-1:0]             r_rd_idx;
    logic                         r_rd_more;
    logic                         r_p_valid;
    logic [IDX_W-1:0]             r_p_idx;
    logic                         r_pend_valid;
    logic [stt_pkg::DATA_W-1:0]   r_pend_id;
    logic [stt_pkg::HANDLE_W-1:0] r_pend_handle;
    logic                         r_any;
    logic [stt_pkg::DATA_W-1:0]   r_max_id;
    logic                         r_free_found;
    logic [IDX_W-1:0]             r_free_idx;
    logic                         r_found;

    logic                         p_live;
    logic                         stage_due;
    logic                         stage_push;
    logic                         advance;
    logic                         stage_go;
    logic                         rd_en;
    logic                         fin_push;
    logic                         fin_done;
    logic                         scan_end;
    logic                         add_write;
    logic [stt_pkg::DATA_W-1:0]   new_id;

    assign p_live     = r_live[r_p_idx];
    assign stage_due  = r_p_valid && (r_cmd.cmd == stt_pkg::CMD_TICK) && p_live &&
                        (r_q_ticks <= stt_pkg::DATA_W'(1));
    assign stage_push = stage_due && r_pend_valid;
    assign advance    = !(stage_push && i_res_full);
    assign stage_go   = (r_state == stt_pkg::BK_SCAN) && r_p_valid && advance;
    assign rd_en      = (r_state == stt_pkg::BK_SCAN) && advance && r_rd_more;
    assign scan_end   = stage_go && (r_p_idx == IDX_W'(MAX_TASKS - 1));
    assign fin_push   = (r_cmd.cmd != stt_pkg::CMD_TICK) || r_pend_valid;
    assign fin_done   = !fin_push || !i_res_full;
    assign add_write  = (r_state == stt_pkg::BK_FINISH) && fin_done &&
                        (r_cmd.cmd == stt_pkg::CMD_ADD) && r_free_found;
    assign new_id     = r_any ? r_max_id + 1'b1 : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            stt_pkg::BK_IDLE: begin
                if (!i_cmd_empty) begin
                    n_state = stt_pkg::BK_SCAN;
                end
            end
            stt_pkg::BK_SCAN: begin
                if (scan_end) begin
                    n_state = stt_pkg::BK_FINISH;
                end
            end
            stt_pkg::BK_FINISH: begin
                if (fin_done) begin
                    n_state = stt_pkg::BK_IDLE;
                end
            end
            default: n_state = stt_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop          = (r_state == stt_pkg::BK_IDLE) && !i_cmd_empty;
        o_res_push         = 1'b0;
        o_res_word.kind    = stt_pkg::KIND_DUE;
        o_res_word.id      = r_pend_id;
        o_res_word.handle  = r_pend_handle;
        o_res_word.success = 1'b1;
        o_res_word.last    = 1'b0;
        case (r_state)
            stt_pkg::BK_SCAN: begin
                o_res_push = stage_push && !i_res_full;
            end
            stt_pkg::BK_FINISH: begin
                o_res_push      = fin_push && !i_res_full;
                o_res_word.last = 1'b1;
                case (r_cmd.cmd)
                    stt_pkg::CMD_ADD: begin
                        o_res_word.kind    = stt_pkg::KIND_ADD;
                        o_res_word.id      = r_free_found ? new_id : '0;
                        o_res_word.handle  = r_free_found ? r_cmd.handle : '0;
                        o_res_word.success = r_free_found;
                    end
                    stt_pkg::CMD_DEL: begin
                        o_res_word.kind    = stt_pkg::KIND_DEL;
                        o_res_word.id      = '0;
                        o_res_word.handle  = '0;
                        o_res_word.success = r_found;
                    end
                    default: begin
                        o_res_word.kind = stt_pkg::KIND_DUE;
                    end
                endcase
            end
            default: begin
                o_res_push = 1'b0;
            end
        endcase
    end

    // Memories: registered read at the scan pointer, one write per cycle.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_q_ticks  <= r_ticks_mem[r_rd_idx];
            r_q_reload <= r_reload_mem[r_rd_idx];
            r_q_id     <= r_id_mem[r_rd_idx];
            r_q_handle <= r_handle_mem[r_rd_idx];
        end
        if (stage_go && r_cmd.cmd == stt_pkg::CMD_TICK && p_live) begin
            if (stage_due) begin
                if (r_q_reload != '0) begin
                    r_ticks_mem[r_p_idx] <= r_q_reload;
                end
            end else begin
                r_ticks_mem[r_p_idx] <= r_q_ticks - 1'b1;
            end
        end else if (add_write) begin
            r_ticks_mem[r_free_idx] <= r_cmd.delay_ticks;
        end
        if (add_write) begin
            r_reload_mem[r_free_idx] <= r_cmd.period_ticks;
            r_id_mem[r_free_idx]     <= new_id;
            r_handle_mem[r_free_idx] <= r_cmd.handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd_word;
        end
        if (stage_go && stage_due) begin
            r_pend_id     <= r_q_id;
            r_pend_handle <= r_q_handle;
        end
        if (stage_go && r_cmd.cmd == stt_pkg::CMD_ADD && p_live &&
            (!r_any || r_q_id > r_max_id)) begin
            r_max_id <= r_q_id;
        end
        if (stage_go && r_cmd.cmd == stt_pkg::CMD_ADD && !p_live && !r_free_found) begin
            r_free_idx <= r_p_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= stt_pkg::BK_IDLE;
            r_rd_idx     <= '0;
            r_rd_more    <= 1'b0;
            r_p_valid    <= 1'b0;
            r_p_idx      <= '0;
            r_pend_valid <= 1'b0;
            r_any        <= 1'b0;
            r_free_found <= 1'b0;
            r_found      <= 1'b0;
            for (int k = 0; k < MAX_TASKS; k++) begin
                r_live[k] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (o_cmd_pop) begin
                r_rd_idx     <= '0;
                r_rd_more    <= 1'b1;
                r_p_valid    <= 1'b0;
                r_pend_valid <= 1'b0;
                r_any        <= 1'b0;
                r_free_found <= 1'b0;
                r_found      <= 1'b0;
            end
            if ((r_state == stt_pkg::BK_SCAN) && advance) begin
                r_p_valid <= r_rd_more;
                r_p_idx   <= r_rd_idx;
                if (r_rd_more) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                    if (r_rd_idx == IDX_W'(MAX_TASKS - 1)) begin
                        r_rd_more <= 1'b0;
                    end
                end
            end
            if (stage_go) begin
                case (r_cmd.cmd)
                    stt_pkg::CMD_TICK: begin
                        if (stage_due) begin
                            r_pend_valid <= 1'b1;
                            if (r_q_reload == '0) begin
                                r_live[r_p_idx] <= 1'b0;
                            end
                        end
                    end
                    stt_pkg::CMD_ADD: begin
                        if (p_live) begin
                            r_any <= 1'b1;
                        end else begin
                            r_free_found <= 1'b1;
                        end
                    end
                    stt_pkg::CMD_DEL: begin
                        if (p_live && r_q_id == r_cmd.target && !r_found) begin
                            r_live[r_p_idx] <= 1'b0;
                            r_found         <= 1'b1;
                        end
                    end
                    default: begin
                        r_found <= r_found;
                    end
                endcase
            end
            if (add_write) begin
                r_live[r_free_idx] <= 1'b1;
            end
            if ((r_state == stt_pkg::BK_FINISH) && fin_done) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

endmodule

### rtl/core/software_timer_task_table.sv
// Top level of the software timer task table.
// Ties together stt_front, two stt_fifo queues and stt_back; uses stt_pkg.
// Usage:
//   Input words enter through push/full: one word is taken at a rising edge
//   with push high and full low. cmd selects tick, add task or delete task;
//   unknown commands are dropped without a result.
//   Results leave through empty/pop as a queue: the oldest result sits on the
//   o_ ports while empty is low and is taken at an edge with pop high.
//   An add or delete gives one result; a tick gives one due result per task
//   that fires, in slot order, and none when nothing fires. last marks the
//   final result of each input word.
// Timing:
//   The front keeps full high while it handles a word; a tick or delete goes
//   straight to its push state, an add first has both times multiplied by a
//   fixed reciprocal of TICK_UNITS. The back walks the table one slot per
//   cycle through a registered read and a stage, then ends in its finish state.
//   A delete's answer thus waits on the whole walk; an add's also on the multiply.
//   A full result queue holds the walk in place; the two-word command queue
//   lets the front keep accepting until it is full too.
// Reset: synchronous, active low; all slots go free and both queues empty.
module software_timer_task_table #(
    parameter int MAX_TASKS  = 16,
    parameter int TICK_UNITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_delay_time,
    input  logic [31:0] i_period_time,
    input  logic [15:0] i_task_handle,
    input  logic [31:0] i_target_id,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_result_kind,
    output logic [31:0] o_task_id,
    output logic [15:0] o_handle_out,
    output logic        o_success,
    output logic        o_last
);

    stt_pkg::t_cmd_word cmd_in;
    stt_pkg::t_cmd_word cmd_out;
    stt_pkg::t_res_word res_in;
    stt_pkg::t_res_word res_out;
    logic               cmd_push;
    logic               cmd_full;
    logic               cmd_pop;
    logic               cmd_empty;
    logic               res_push;
    logic               res_full;

    // Accept and classify; divide add times down to ticks.
    stt_front #(
        .TICK_UNITS (TICK_UNITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_cmd         (i_cmd),
        .i_delay_time  (i_delay_time),
        .i_period_time (i_period_time),
        .i_task_handle (i_task_handle),
        .i_target_id   (i_target_id),
        .o_cmd_push    (cmd_push),
        .o_cmd_word    (cmd_in),
        .i_cmd_full    (cmd_full)
    );

    // Hold classified commands between front and back.
    stt_fifo #(
        .WIDTH ($bits(stt_pkg::t_cmd_word)),
        .DEPTH (stt_pkg::QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    // Walk the task table and produce result words.
    stt_back #(
        .MAX_TASKS (MAX_TASKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd_word  (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res_word  (res_in),
        .i_res_full  (res_full)
    );

    // Decouple the back from a stalling receiver.
    stt_fifo #(
        .WIDTH ($bits(stt_pkg::t_res_word)),
        .DEPTH (stt_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_result_kind = res_out.kind;
    assign o_task_id     = res_out.id;
    assign o_handle_out  = res_out.handle;
    assign o_success     = res_out.success;
    assign o_last        = res_out.last;

endmodule
